[hdl/hbd_pkg.sv]
// Shared types, codes and constants of the slew-limited H-bridge PWM drive.
package hbd_pkg;

  // Input mode codes (any other mode, or enable low, coasts)
  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_BRAKE = 2'd1;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_DUTY   = 3'd0;
  localparam logic [2:0] CFG_DEADBAND   = 3'd1;
  localparam logic [2:0] CFG_SLEW       = 3'd2;
  localparam logic [2:0] CFG_PWM_FULL   = 3'd3;
  localparam logic [2:0] CFG_A_IS_LEFT  = 3'd4;
  localparam logic [2:0] CFG_INV_LEFT   = 3'd5;
  localparam logic [2:0] CFG_INV_RIGHT  = 3'd6;

  // Exact floor(x / 1000) for x < 2^31: (x * RECIP_MUL) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_MUL   = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;
  localparam logic [15:0] STEP_MAX    = 16'hFFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_SLEW,
    ST_MUL_RECIP,
    ST_SLEW,
    ST_TICK_L,
    ST_TICK_R,
    ST_DONE
  } seq_state_t;

  // Operand selection for the shared multiplier
  typedef enum logic [1:0] {
    MOP_SLEW,
    MOP_RECIP,
    MOP_TICK
  } mul_op_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    mul_en;
    mul_op_t mul_op;
    logic    slew_upd;
    logic    side_right;
    logic    cap_left;
    logic    cap_right;
    logic    out_load;
  } seq_ctl_t;

  // One side after clamp, inversion and deadband
  typedef struct packed {
    logic        pos;
    logic        neg;
    logic [14:0] mag;
  } side_drv_t;

  // Move cur toward tgt by at most step
  function automatic logic signed [15:0] slew_toward(input logic signed [15:0] cur,
                                                     input logic signed [15:0] tgt,
                                                     input logic [15:0]        step);
    logic signed [17:0] err;
    logic signed [17:0] stp;
    logic signed [17:0] res;
    err = 18'(tgt) - 18'(cur);
    stp = $signed({2'b00, step});
    if (err > stp) begin
      res = 18'(cur) + stp;
    end else if (err < -stp) begin
      res = 18'(cur) - stp;
    end else begin
      res = 18'(tgt);
    end
    return $signed(res[15:0]);
  endfunction

endpackage

[hdl/hbd_mul.sv]
// Shared 32x32 multiplier with a registered product.
module hbd_mul
  import hbd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  logic [63:0] p_nxt;

  // Form the full product
  assign p_nxt = 64'(a) * 64'(b);

  // Hold the product until the next enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

[hdl/hbd_side.sv]
// Per-side duty conditioning: clamp, inversion, deadband and sign split.
module hbd_side
  import hbd_pkg::*;
(
  input  logic signed [15:0] duty,
  input  logic               inv,
  input  logic [14:0]        max_duty,
  input  logic [14:0]        deadband,
  output side_drv_t          drv
);

  logic signed [15:0] lim;
  logic signed [15:0] clamped;
  logic signed [15:0] oriented;
  logic [15:0]        abs_duty;
  logic               in_band;

  always_comb begin
    lim = $signed({1'b0, max_duty});
    // Clamp to +-max_duty
    if (duty > lim) begin
      clamped = lim;
    end else if (duty < -lim) begin
      clamped = -lim;
    end else begin
      clamped = duty;
    end
    // Flip for chassis wiring
    oriented = inv ? -clamped : clamped;
    abs_duty = oriented[15] ? 16'(-oriented) : 16'(oriented);
    // Drop magnitudes inside the deadband
    in_band  = abs_duty[14:0] < deadband;
    drv.pos  = !in_band && !oriented[15] && (oriented != 16'sd0);
    drv.neg  = !in_band && oriented[15];
    drv.mag  = in_band ? 15'd0 : abs_duty[14:0];
  end

endmodule

[hdl/hbd_seq.sv]
// Sequencer that steps one control item through the shared multiplier.
module hbd_seq
  import hbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     run,
  input  logic     out_free,
  output seq_ctl_t ctl
);

  seq_state_t state_r;
  seq_state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = run ? ST_MUL_SLEW : ST_DONE;
        end
      end
      ST_MUL_SLEW:  state_nxt = ST_MUL_RECIP;
      ST_MUL_RECIP: state_nxt = ST_SLEW;
      ST_SLEW:      state_nxt = ST_TICK_L;
      ST_TICK_L:    state_nxt = ST_TICK_R;
      ST_TICK_R:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    ctl.mul_op = MOP_SLEW;
    case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.capture  = in_valid;
      end
      ST_MUL_SLEW: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MOP_SLEW;
      end
      ST_MUL_RECIP: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = MOP_RECIP;
      end
      ST_SLEW: begin
        ctl.slew_upd = 1'b1;
      end
      ST_TICK_L: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_op   = MOP_TICK;
        ctl.cap_left = 1'b1;
      end
      ST_TICK_R: begin
        ctl.mul_en     = 1'b1;
        ctl.mul_op     = MOP_TICK;
        ctl.side_right = 1'b1;
        ctl.cap_right  = 1'b1;
      end
      ST_DONE: begin
        ctl.out_load = out_free;
      end
      default: begin
        ctl.in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hdl/slew_limited_hbridge_pwm_drive_unit.sv]
// Slew-limited sign-magnitude H-bridge PWM drive for two motors (top level).
//
// One control item yields one result item. A run item passes through the
// states MUL_SLEW, MUL_RECIP, SLEW, TICK_L, TICK_R and DONE before the next
// item can be taken; a brake or coast item passes through DONE only, and DONE
// waits for a free output register. The run steps are set by the single
// shared 32x32 multiplier, which forms in turn slew*elapsed, the division by
// 1000 as a reciprocal product, and the left and right tick products. Input
// is taken only while the sequencer is idle; a finished result waits in the
// output register and does not block the next item from being taken.
// Configuration writes are always accepted and are meant for idle periods.
module slew_limited_hbridge_pwm_drive_unit
  import hbd_pkg::*;
#(
  parameter int DUTY_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // Control items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_left, target_right, elapsed_us
  input  logic [2:0]  in_tuser,   // mode[1:0], enable[2]
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // chip_a_in1, chip_a_in2, chip_b_in1, chip_b_in2,
                                  // applied_left_out, applied_right_out
  output logic [0:0]  out_tuser,  // bridge_enable
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [15:0] FULL_MAG = 16'(32'd1 << DUTY_FRAC_BITS);

  // Configuration registers
  logic [14:0] max_duty_r;
  logic [14:0] deadband_r;
  logic [14:0] slew_r;
  logic [15:0] pwm_full_r;
  logic        a_is_left_r;
  logic        inv_left_r;
  logic        inv_right_r;

  // Item registers
  logic signed [15:0] tgt_left_r;
  logic signed [15:0] tgt_right_r;
  logic [15:0]        elapsed_r;
  logic               en_r;
  logic               run_r;
  logic               brake_r;
  logic signed [15:0] app_left_r;
  logic signed [15:0] app_right_r;

  // Intermediate side results
  logic        l_pos_r;
  logic        l_neg_r;
  logic [15:0] l_ticks_r;
  logic        r_pos_r;
  logic        r_neg_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] a1_r, a2_r, b1_r, b2_r;
  logic        out_en_r;
  logic [15:0] out_app_l_r;
  logic [15:0] out_app_r_r;

  seq_ctl_t           ctl;
  logic               in_run;
  logic               out_free;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic [63-RECIP_SHIFT:0] quot;
  logic [15:0]        step;
  logic signed [15:0] side_duty;
  logic               side_inv;
  side_drv_t          drv;
  logic [15:0]        mag_ext;
  logic [15:0]        mag_c;
  logic [15:0]        ticks;
  logic [15:0]        l1, l2, r1, r2;

  assign in_run    = in_tuser[2] && (in_tuser[1:0] == MODE_RUN);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = ctl.in_ready;
  assign cfg_ready = 1'b1;

  hbd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .run      (in_run),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // Select multiplier operands
  always_comb begin
    case (ctl.mul_op)
      MOP_SLEW: begin
        mul_a = {17'd0, slew_r};
        mul_b = {16'd0, elapsed_r};
      end
      MOP_RECIP: begin
        mul_a = {1'b0, prod[30:0]};
        mul_b = RECIP_MUL;
      end
      MOP_TICK: begin
        mul_a = {16'd0, mag_c};
        mul_b = {16'd0, pwm_full_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hbd_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // Saturate the slew step
  assign quot = prod[63:RECIP_SHIFT];
  assign step = (quot > (64-RECIP_SHIFT)'(STEP_MAX)) ? STEP_MAX : quot[15:0];

  // Condition the side being converted
  assign side_duty = ctl.side_right ? app_right_r : app_left_r;
  assign side_inv  = ctl.side_right ? inv_right_r : inv_left_r;

  hbd_side u_side (
    .duty     (side_duty),
    .inv      (side_inv),
    .max_duty (max_duty_r),
    .deadband (deadband_r),
    .drv      (drv)
  );

  // Limit magnitude to full scale, take ticks from the product
  assign mag_ext = {1'b0, drv.mag};
  assign mag_c   = (mag_ext > FULL_MAG) ? FULL_MAG : mag_ext;
  assign ticks   = prod[DUTY_FRAC_BITS +: 16];

  assign l1 = l_pos_r ? l_ticks_r : 16'd0;
  assign l2 = l_neg_r ? l_ticks_r : 16'd0;
  assign r1 = r_pos_r ? ticks : 16'd0;
  assign r2 = r_neg_r ? ticks : 16'd0;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r  <= 15'h7FFF;
      deadband_r  <= 15'd0;
      slew_r      <= 15'h7FFF;
      pwm_full_r  <= 16'd255;
      a_is_left_r <= 1'b1;
      inv_left_r  <= 1'b0;
      inv_right_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_DUTY:  max_duty_r  <= cfg_data[14:0];
        CFG_DEADBAND:  deadband_r  <= cfg_data[14:0];
        CFG_SLEW:      slew_r      <= cfg_data[14:0];
        CFG_PWM_FULL:  pwm_full_r  <= cfg_data;
        CFG_A_IS_LEFT: a_is_left_r <= cfg_data[0];
        CFG_INV_LEFT:  inv_left_r  <= cfg_data[0];
        CFG_INV_RIGHT: inv_right_r <= cfg_data[0];
        default:       max_duty_r  <= max_duty_r;
      endcase
    end
  end

  // Track applied duties and item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_left_r  <= 16'sd0;
      app_right_r <= 16'sd0;
      run_r       <= 1'b0;
      brake_r     <= 1'b0;
      en_r        <= 1'b0;
    end else if (ctl.capture) begin
      run_r   <= in_run;
      brake_r <= in_tuser[2] && (in_tuser[1:0] == MODE_BRAKE);
      en_r    <= in_tuser[2];
      if (!in_run) begin
        app_left_r  <= 16'sd0;
        app_right_r <= 16'sd0;
      end
    end else if (ctl.slew_upd) begin
      app_left_r  <= slew_toward(app_left_r, tgt_left_r, step);
      app_right_r <= slew_toward(app_right_r, tgt_right_r, step);
    end
  end

  // Capture item payload
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      tgt_left_r  <= $signed(in_tdata[15:0]);
      tgt_right_r <= $signed(in_tdata[31:16]);
      elapsed_r   <= in_tdata[47:32];
    end
  end

  // Hold side signs and left ticks
  always_ff @(posedge clk) begin
    if (ctl.cap_left) begin
      l_pos_r <= drv.pos;
      l_neg_r <= drv.neg;
    end
    if (ctl.cap_right) begin
      l_ticks_r <= ticks;
      r_pos_r   <= drv.pos;
      r_neg_r   <= drv.neg;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_en_r    <= en_r;
      out_app_l_r <= app_left_r;
      out_app_r_r <= app_right_r;
      if (run_r) begin
        a1_r <= a_is_left_r ? l1 : r1;
        a2_r <= a_is_left_r ? l2 : r2;
        b1_r <= a_is_left_r ? r1 : l1;
        b2_r <= a_is_left_r ? r2 : l2;
      end else if (brake_r) begin
        a1_r <= pwm_full_r;
        a2_r <= pwm_full_r;
        b1_r <= pwm_full_r;
        b2_r <= pwm_full_r;
      end else begin
        a1_r <= 16'd0;
        a2_r <= 16'd0;
        b1_r <= 16'd0;
        b2_r <= 16'd0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_app_r_r, out_app_l_r, b2_r, b1_r, a2_r, a1_r};
  assign out_tuser  = out_en_r;

endmodule

[hdl/hbd_chk.sv]
// Port-level checker for the H-bridge drive, bound to the top level.
module hbd_chk
  import hbd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  logic in_fire;
  logic is_run;
  logic out_free;

  assign in_fire  = in_tvalid && in_tready;
  assign is_run   = in_tuser[2] && (in_tuser[1:0] == MODE_RUN);
  assign out_free = !out_tvalid || out_tready;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("item taken while a previous one is in work");

  // Disabled item drives everything to zero
  a_coast: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser[2] && out_free |=> ##1 out_tvalid && (out_tdata == 96'd0))
    else $error("disabled item did not give an all-zero result");

  // Run item result appears after the multiply sequence
  a_run_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_run && out_free |=> ##6 out_tvalid)
    else $error("run result missing after the sequence");

endmodule

bind slew_limited_hbridge_pwm_drive_unit hbd_chk u_hbd_chk (.*);
